// ===== rtl/hit_phi_wedge_assigner_assert.svh =====
// Assertion macros for the hit phi wedge assigner.
`ifndef HIT_PHI_WEDGE_ASSIGNER_ASSERT_SVH
`define HIT_PHI_WEDGE_ASSIGNER_ASSERT_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/hpwa_pkg.sv =====
// Shared constants, types and tables of the hit phi wedge assigner.
`timescale 1ns / 1ps
package hpwa_pkg;
  localparam int NUM_WEDGES   = 128;
  localparam int NUM_LAYERS   = 4;
  localparam int ANGLE_BITS   = 24;
  localparam int WEDGE_BITS   = $clog2(NUM_WEDGES);
  localparam int WEDGE_SHIFT  = ANGLE_BITS - WEDGE_BITS;
  localparam int ACC_BITS     = 32;
  localparam int ROUND_SHIFT  = ACC_BITS - ANGLE_BITS;
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_BITS  = 36;
  localparam int RADIUS_BITS  = 24;
  localparam int SQ_BITS      = 47;
  localparam int REM_BITS     = 49;
  localparam int CORDIC_FIRST = 1;
  localparam int SQRT_FIRST   = 3;
  localparam int ROUND_STAGE  = CORDIC_FIRST + CORDIC_STEPS;
  localparam int NUM_STAGES   = SQRT_FIRST + RADIUS_BITS;
  localparam int CFG_IDX_BITS = 4;
  localparam int CFG_DATA_BITS = 23;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_VOLUME  = 4'd0,
    REG_ZMAX0   = 4'd1,
    REG_ZMAX1   = 4'd2,
    REG_ZMAX2   = 4'd3,
    REG_ZMAX3   = 4'd4,
    REG_EXPAND1 = 4'd5,
    REG_EXPAND2 = 4'd6,
    REG_EXPAND3 = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [62:0]                   hit_id;
    logic [1:0]                    lidx;
    logic signed [23:0]            x_raw;
    logic signed [23:0]            y_raw;
    logic signed [23:0]            z_raw;
    logic [15:0]                   expand;
    logic                          origin;
    logic signed [CORDIC_BITS-1:0] cx;
    logic signed [CORDIC_BITS-1:0] cy;
    logic [ACC_BITS-1:0]           acc;
    logic [SQ_BITS-1:0]            xsq;
    logic [SQ_BITS-1:0]            ysq;
    logic [REM_BITS-1:0]           rem;
    logic [RADIUS_BITS-1:0]        root;
    logic [ANGLE_BITS-1:0]         az;
  } stage_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [ACC_BITS-1:0] atan_lut(input logic [4:0] i);
    logic [ACC_BITS-1:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

// ===== rtl/hpwa_if.sv =====
// Channel interfaces: hit input, wedge result output, configuration write.
`timescale 1ns / 1ps
interface hpwa_hit_if;
  import hpwa_pkg::*;
  logic               valid;
  logic               ready;
  logic [62:0]        hit_id;
  logic [7:0]         vol_num;
  logic [7:0]         layer_num;
  logic signed [23:0] x_pos;
  logic signed [23:0] y_pos;
  logic signed [23:0] z_pos;
  modport source (output valid, hit_id, vol_num, layer_num, x_pos, y_pos, z_pos,
                  input ready);
  modport sink (input valid, hit_id, vol_num, layer_num, x_pos, y_pos, z_pos,
                output ready);
endinterface

interface hpwa_wedge_if;
  import hpwa_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [62:0]            out_hit_id;
  logic [1:0]             layer_idx;
  logic [WEDGE_BITS-1:0]  wedge_num;
  logic signed [23:0]     out_x;
  logic signed [23:0]     out_y;
  logic signed [23:0]     out_z;
  logic [RADIUS_BITS-1:0] radius;
  logic [ANGLE_BITS-1:0]  azimuth;
  logic                   last;
  modport source (output valid, out_hit_id, layer_idx, wedge_num, out_x, out_y,
                  out_z, radius, azimuth, last, input ready);
  modport sink (input valid, out_hit_id, layer_idx, wedge_num, out_x, out_y,
                out_z, radius, azimuth, last, output ready);
endinterface

interface hpwa_cfg_if;
  import hpwa_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/hit_phi_wedge_assigner.sv =====
// Top level: hit filter, radius and azimuth pipeline, phi wedge result emitter.
//
//   channel    dir  handshake      carries
//   hit_in     in   valid/ready    hit id, volume, layer, x, y, z
//   wedge_out  out  valid/ready    hit fields, layer index, wedge, radius, azimuth, last
//   cfg        in   valid/ready    register index, write data
//
// A kept hit passes through the pipeline into the output register, which gives its
// first result. A hit is taken every cycle while the output register does not hold;
// a hit that falls in two widened wedges holds the output register until both of its
// results are taken, so the rate is set by the single output register.
// rst clears the valid bits and the output register's valid state, and loads the
// configuration registers with their defaults.
// A stalled output freezes the whole pipeline; nothing moves, nothing is lost.
`timescale 1ns / 1ps
`include "hit_phi_wedge_assigner_assert.svh"
module hit_phi_wedge_assigner (
  input  logic                clk,
  input  logic                rst,
  hpwa_hit_if.sink            hit_in,
  hpwa_wedge_if.source        wedge_out,
  hpwa_cfg_if.sink            cfg
);
  import hpwa_pkg::*;

  // configuration registers
  logic [7:0]  volume_select;
  logic [22:0] zmax [4];
  logic [15:0] expand [4];

  // pipeline
  stage_t pipe [NUM_STAGES];
  logic   vld  [NUM_STAGES];
  logic   en;

  // output register
  stage_t              em_d;
  logic                em_valid;
  logic                em_two;
  logic                em_second;
  logic [WEDGE_BITS-1:0] em_w0;
  logic [WEDGE_BITS-1:0] em_w1;
  logic                em_last_now;

  // input filter
  logic [7:0]          idx_wide;
  logic                keep;
  logic signed [24:0]  z_ext;
  logic signed [24:0]  zm_ext;
  stage_t              s0;

  // wedge selection
  stage_t              tail;
  logic [WEDGE_BITS-1:0] w_mid;
  logic [WEDGE_BITS-1:0] w_lo;
  logic [WEDGE_BITS-1:0] w_hi;
  logic                in_lo;
  logic                in_hi;
  logic                two_next;
  logic [WEDGE_BITS-1:0] w0_next;
  logic [WEDGE_BITS-1:0] w1_next;

  // wedge c covers az when az lies within [start, start + span] modulo the turn
  function automatic logic wedge_hit(input logic [WEDGE_BITS-1:0] c,
                                     input logic [ANGLE_BITS-1:0] az,
                                     input logic [15:0] e);
    logic [ANGLE_BITS-1:0] start;
    logic [ANGLE_BITS-1:0] az_off;
    logic [ANGLE_BITS-1:0] span;
    start  = {c, {WEDGE_SHIFT{1'b0}}} - ANGLE_BITS'(e);
    az_off = az - start;
    span   = ANGLE_BITS'(1 << WEDGE_SHIFT) + ANGLE_BITS'({e, 1'b0});
    return az_off <= span;
  endfunction

  // configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_select <= 8'd8;
      zmax[0]   <= 23'd1402523;
      zmax[1]   <= 23'd1919549;
      zmax[2]   <= 23'd2489909;
      zmax[3]   <= 23'd3216376;
      expand[0] <= 16'd0;
      expand[1] <= 16'd3191;
      expand[2] <= 16'd6711;
      expand[3] <= 16'd11195;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_VOLUME:  volume_select <= cfg.data[7:0];
        REG_ZMAX0:   zmax[0] <= cfg.data;
        REG_ZMAX1:   zmax[1] <= cfg.data;
        REG_ZMAX2:   zmax[2] <= cfg.data;
        REG_ZMAX3:   zmax[3] <= cfg.data;
        REG_EXPAND1: expand[1] <= cfg.data[15:0];
        REG_EXPAND2: expand[2] <= cfg.data[15:0];
        REG_EXPAND3: expand[3] <= cfg.data[15:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // advance the whole pipeline unless the output register must hold
  assign em_last_now = em_two ? em_second : 1'b1;
  assign en          = !em_valid || (wedge_out.ready && em_last_now);
  assign hit_in.ready = en;

  // filter: volume, layer index in range, z strictly inside the layer window
  always_comb begin
    idx_wide = {1'b0, hit_in.layer_num[7:1]} - 8'd1;
    z_ext    = 25'(hit_in.z_pos);
    zm_ext   = $signed({2'b0, zmax[idx_wide[1:0]]});
    keep     = (hit_in.vol_num == volume_select) && (hit_in.layer_num >= 8'd2) &&
               (idx_wide < 8'(NUM_LAYERS)) && (idx_wide < 8'd4) &&
               (z_ext < zm_ext) && (z_ext > -zm_ext);

    s0        = '0;
    s0.hit_id = hit_in.hit_id;
    s0.lidx   = idx_wide[1:0];
    s0.x_raw  = hit_in.x_pos;
    s0.y_raw  = hit_in.y_pos;
    s0.z_raw  = hit_in.z_pos;
    s0.expand = expand[idx_wide[1:0]];
    s0.origin = (hit_in.x_pos == '0) && (hit_in.y_pos == '0);
    // scale by 256; fold the left half plane onto the right, starting at a half turn
    s0.cx = {{(CORDIC_BITS-32){hit_in.x_pos[23]}}, hit_in.x_pos, 8'b0};
    s0.cy = {{(CORDIC_BITS-32){hit_in.y_pos[23]}}, hit_in.y_pos, 8'b0};
    if (hit_in.x_pos[23]) begin
      s0.cx  = -s0.cx;
      s0.cy  = -s0.cy;
      s0.acc = ACC_BITS'(1) << (ACC_BITS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= hit_in.valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= s0;
    end
  end

  // stages 1..24: one CORDIC rotation each; 25: azimuth rounding; 1: squares; 2: sum; 3..26: one root bit each
  for (genvar s = 1; s < NUM_STAGES; s++) begin : g_stage
    localparam int B = SQRT_FIRST + RADIUS_BITS - 1 - s;
    stage_t                         nxt;
    logic signed [CORDIC_BITS-1:0]  dx;
    logic signed [CORDIC_BITS-1:0]  dy;
    logic signed [47:0]             xs2;
    logic signed [47:0]             ys2;
    logic [REM_BITS:0]              trial;
    logic [ACC_BITS-1:0]            rounded;

    always_comb begin
      nxt     = pipe[s-1];
      dx      = pipe[s-1].cy >>> (s - 1);
      dy      = pipe[s-1].cx >>> (s - 1);
      xs2     = pipe[s-1].x_raw * pipe[s-1].x_raw;
      ys2     = pipe[s-1].y_raw * pipe[s-1].y_raw;
      trial   = ((REM_BITS+1)'(pipe[s-1].root) << (B + 1)) + ((REM_BITS+1)'(1) << (2 * B));
      rounded = pipe[s-1].acc + ACC_BITS'(1 << (ROUND_SHIFT - 1));
      if (s >= CORDIC_FIRST && s < CORDIC_FIRST + CORDIC_STEPS) begin
        if (!pipe[s-1].cy[CORDIC_BITS-1]) begin
          nxt.cx  = pipe[s-1].cx + dx;
          nxt.cy  = pipe[s-1].cy - dy;
          nxt.acc = pipe[s-1].acc + atan_lut(5'(s - 1));
        end else begin
          nxt.cx  = pipe[s-1].cx - dx;
          nxt.cy  = pipe[s-1].cy + dy;
          nxt.acc = pipe[s-1].acc - atan_lut(5'(s - 1));
        end
      end
      if (s == SQRT_FIRST - 2) begin
        nxt.xsq = xs2[SQ_BITS-1:0];
        nxt.ysq = ys2[SQ_BITS-1:0];
      end
      if (s == SQRT_FIRST - 1) begin
        nxt.rem  = REM_BITS'(pipe[s-1].xsq) + REM_BITS'(pipe[s-1].ysq);
        nxt.root = '0;
      end
      if (s >= SQRT_FIRST) begin
        if ({1'b0, pipe[s-1].rem} >= trial) begin
          nxt.rem  = pipe[s-1].rem - trial[REM_BITS-1:0];
          nxt.root = pipe[s-1].root | RADIUS_BITS'(32'd1 << B);
        end
      end
      if (s == ROUND_STAGE) begin
        nxt.az = pipe[s-1].origin ? '0 : rounded[ACC_BITS-1:ROUND_SHIFT];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pipe[s] <= nxt;
      end
    end
  end

  // the home wedge always matches; a neighbor matches only within the margin
  always_comb begin
    tail  = pipe[NUM_STAGES-1];
    w_mid = tail.az[ANGLE_BITS-1:WEDGE_SHIFT];
    w_lo  = w_mid - WEDGE_BITS'(1);
    w_hi  = w_mid + WEDGE_BITS'(1);
    in_lo = wedge_hit(w_lo, tail.az, tail.expand);
    in_hi = wedge_hit(w_hi, tail.az, tail.expand);
    two_next = in_lo || in_hi;
    w0_next  = w_mid;
    w1_next  = w_mid;
    if (in_lo) begin
      w0_next = (w_lo < w_mid) ? w_lo : w_mid;
      w1_next = (w_lo < w_mid) ? w_mid : w_lo;
    end else if (in_hi) begin
      w0_next = (w_hi < w_mid) ? w_hi : w_mid;
      w1_next = (w_hi < w_mid) ? w_mid : w_hi;
    end
  end

  // output register: hold one hit, step through its one or two wedges
  always_ff @(posedge clk) begin
    if (rst) begin
      em_valid  <= 1'b0;
      em_second <= 1'b0;
      em_two    <= 1'b0;
    end else if (en) begin
      em_valid  <= vld[NUM_STAGES-1];
      em_second <= 1'b0;
      em_two    <= two_next;
    end else if (wedge_out.ready) begin
      em_second <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      em_d  <= tail;
      em_w0 <= w0_next;
      em_w1 <= w1_next;
    end
  end

  assign wedge_out.valid       = em_valid;
  assign wedge_out.out_hit_id  = em_d.hit_id;
  assign wedge_out.layer_idx   = em_d.lidx;
  assign wedge_out.wedge_num   = em_second ? em_w1 : em_w0;
  assign wedge_out.out_x       = em_d.x_raw;
  assign wedge_out.out_y       = em_d.y_raw;
  assign wedge_out.out_z       = em_d.z_raw;
  assign wedge_out.radius      = em_d.root;
  assign wedge_out.azimuth     = em_d.az;
  assign wedge_out.last        = em_last_now;

  `ASSERT_NEXT(a_second_follows, em_valid && em_two && !em_second && wedge_out.ready,
               em_valid && em_second, "second wedge result did not follow the first")
  `ASSERT_IMPL(a_second_needs_two, em_second, em_two && em_valid,
               "second result flagged on a single-wedge hit")
  `ASSERT_IMPL(a_wedges_ascend, em_valid && em_two, em_w0 < em_w1,
               "wedge results not in ascending order")
  `ASSERT_IMPL(a_stall_holds, !hit_in.ready, em_valid && !(wedge_out.ready && em_last_now),
               "input stalled while the output register could drain")
endmodule
